/* rtl/core/dq_pkg.sv */
// Shared types and codes for the double-ended queue controller and datapath.
package dq_pkg;

   // Operation selector carried with each request beat.
   typedef enum logic [1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_BACK  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   // Result status carried with each response beat.
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_EMIT = 2'd2
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic load_out;
   } cmd_type;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned OCC_W   = 7;

endpackage

/* rtl/core/double_ended_queue.sv */
// Top level of the double-ended queue: controller and datapath.
// A bounded double-ended queue of 32-bit words held in a ring buffer of CAPACITY
// entries. Each request beat pushes at the front, pushes at the back,
// pops from the front or pops from the back, and yields exactly one response beat
// with a status (done, pop on empty, push on full), the popped word (zero unless a
// pop succeeded) and the occupancy after the operation, masked to 7 bits. A full
// queue drops the pushed word; an empty queue leaves everything unchanged. One
// operation is handled at a time and occupies three controller states: accept,
// execute (pointer update plus the single memory write or registered read) and
// emit. A new request is therefore accepted only after the previous one has left
// emit; the response beat is valid once emit loads it. The response sits in an output
// register, so the next request is accepted while it waits to be taken; emit holds
// only while the previous response beat has still not been taken.
// The word memory needs no clearing after reset; the block is ready at once.
module double_ended_queue #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] popped_value, [38:32] occupancy, [39] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   dq_pkg::cmd_type            cmd;
   logic [1:0]                 rsp_status;
   logic [dq_pkg::VALUE_W-1:0] rsp_popped;
   logic [dq_pkg::OCC_W-1:0]   rsp_occupancy;

   dq_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   dq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_kind      (req_tuser),
      .req_value     (req_tdata),
      .rsp_status    (rsp_status),
      .rsp_popped    (rsp_popped),
      .rsp_occupancy (rsp_occupancy)
   );

   // Pack the response beat.
   assign rsp_tdata = {1'b0, rsp_occupancy, rsp_popped};
   assign rsp_tuser = rsp_status;

endmodule

/* rtl/core/dq_datapath.sv */
// Datapath of the double-ended queue: word memory, ring pointers and result registers.
module dq_datapath #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dq_pkg::cmd_type               cmd,
   input  logic [1:0]                    req_kind,
   input  logic [dq_pkg::VALUE_W-1:0]    req_value,
   output logic [1:0]                    rsp_status,
   output logic [dq_pkg::VALUE_W-1:0]    rsp_popped,
   output logic [dq_pkg::OCC_W-1:0]      rsp_occupancy
);

   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned SW = CW + 1;
   localparam int unsigned EW = (CW > dq_pkg::OCC_W) ? CW : dq_pkg::OCC_W;
   localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
   localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
   localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);

   // Word storage; entries are only read after being written.
   logic [dq_pkg::VALUE_W-1:0] store_mem [CAPACITY];

   dq_pkg::kind_type           kind_ff, kind_in;
   logic [dq_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [IW-1:0]              front_ff, front_in;
   logic [CW-1:0]              count_ff, count_in;
   dq_pkg::status_type         status_ff, status_in;
   logic                       pop_ok_ff, pop_ok_in;
   logic [dq_pkg::VALUE_W-1:0] rd_data_ff;
   logic [1:0]                 out_status_ff, out_status_in;
   logic [dq_pkg::VALUE_W-1:0] out_popped_ff, out_popped_in;
   logic [dq_pkg::OCC_W-1:0]   out_occ_ff, out_occ_in;

   logic          full, empty;
   logic [IW-1:0] front_dec, front_inc;
   logic [SW-1:0] back_push_sum, back_pop_sum;
   logic [IW-1:0] back_push_pos, back_pop_pos;
   logic          wr_en, rd_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] count_ext;

   // Ring position arithmetic; sums stay below twice the capacity.
   always_comb begin
      full          = (count_ff == CAP_C);
      empty         = (count_ff == '0);
      front_dec     = (front_ff == '0) ? LAST_I : front_ff - 1'b1;
      front_inc     = (front_ff == LAST_I) ? '0 : front_ff + 1'b1;
      back_push_sum = SW'(front_ff) + SW'(count_ff);
      back_pop_sum  = back_push_sum - 1'b1;
      back_push_pos = (back_push_sum >= CAP_S) ? back_push_sum[IW-1:0] - CAP_S[IW-1:0]
                                               : back_push_sum[IW-1:0];
      back_pop_pos  = (back_pop_sum >= CAP_S) ? back_pop_sum[IW-1:0] - CAP_S[IW-1:0]
                                              : back_pop_sum[IW-1:0];
   end

   // Operation decode and pointer update.
   always_comb begin
      kind_in   = kind_ff;
      value_in  = value_ff;
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = front_dec;
      rd_addr   = front_ff;
      if (cmd.capture) begin
         kind_in  = dq_pkg::kind_type'(req_kind);
         value_in = req_value;
      end
      if (cmd.execute) begin
         status_in = dq_pkg::STATUS_DONE;
         pop_ok_in = 1'b0;
         case (kind_ff)
            dq_pkg::KIND_PUSH_FRONT: begin
               if (full) begin
                  status_in = dq_pkg::STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  front_in = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            dq_pkg::KIND_PUSH_BACK: begin
               if (full) begin
                  status_in = dq_pkg::STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = back_push_pos;
                  count_in = count_ff + 1'b1;
               end
            end
            dq_pkg::KIND_POP_FRONT: begin
               if (empty) begin
                  status_in = dq_pkg::STATUS_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = front_ff;
                  pop_ok_in = 1'b1;
                  front_in  = front_inc;
                  count_in  = count_ff - 1'b1;
               end
            end
            dq_pkg::KIND_POP_BACK: begin
               if (empty) begin
                  status_in = dq_pkg::STATUS_EMPTY;
               end else begin
                  rd_en     = 1'b1;
                  rd_addr   = back_pop_pos;
                  pop_ok_in = 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
            default: begin
               status_in = dq_pkg::STATUS_DONE;
            end
         endcase
      end
   end

   // Result payload for the output register.
   always_comb begin
      count_ext     = EW'(count_ff);
      out_status_in = out_status_ff;
      out_popped_in = out_popped_ff;
      out_occ_in    = out_occ_ff;
      if (cmd.load_out) begin
         out_status_in = status_ff;
         out_popped_in = pop_ok_ff ? rd_data_ff : '0;
         out_occ_in    = count_ext[dq_pkg::OCC_W-1:0];
      end
   end

   // Pointer state is cleared by reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      pop_ok_ff     <= pop_ok_in;
      out_status_ff <= out_status_in;
      out_popped_ff <= out_popped_in;
      out_occ_ff    <= out_occ_in;
   end

   // Single write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_status    = out_status_ff;
   assign rsp_popped    = out_popped_ff;
   assign rsp_occupancy = out_occ_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("occupancy exceeds capacity");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= LAST_I)
      else $error("front pointer out of range");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && !full && (kind_ff == dq_pkg::KIND_PUSH_FRONT ||
       kind_ff == dq_pkg::KIND_PUSH_BACK)) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("successful push did not grow the queue");

   a_empty_pop_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && empty && (kind_ff == dq_pkg::KIND_POP_FRONT ||
       kind_ff == dq_pkg::KIND_POP_BACK)) |=> ($stable(count_ff) && $stable(front_ff)))
      else $error("pop on empty queue changed the pointers");
`endif

endmodule

/* rtl/core/dq_controller.sv */
// Controller state machine of the double-ended queue: sequences accept, execute and emit.
module dq_controller (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output dq_pkg::cmd_type cmd
);

   dq_pkg::state_type state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         dq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = dq_pkg::ST_EXEC;
            end
         end
         dq_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = dq_pkg::ST_EMIT;
         end
         dq_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = dq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   // Output beat valid: set on load, cleared when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == dq_pkg::ST_EXEC))
      else $error("accepted beat not executed next cycle");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten before it was taken");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.execute, cmd.load_out}))
      else $error("more than one datapath command at once");
`endif

endmodule
